// ===== rtl/bf_pkg.sv =====
package bf_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int REG_WIDTH      = 31;
  localparam int FRAC_BITS      = 16;
  localparam int MAG_LIMIT_BITS = 62;
  localparam int LANES          = 3;

  localparam logic [REG_WIDTH-1:0] REST_LENGTH_RESET      = REG_WIDTH'(0);
  localparam logic [REG_WIDTH-1:0] SPRING_STIFFNESS_RESET = REG_WIDTH'(65536);

  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_REST_LENGTH      = 2'd0,
    CFG_SPRING_STIFFNESS = 2'd1
  } cfg_index_t;

endpackage

// ===== rtl/bungee_force_core.sv =====
// Bungee cord force: one-sided Hooke spring between a body and another end.
// Input channel (in_valid/in_stall) carries the body and other-end positions,
// output channel (out_valid/out_stall) carries the force vector and the slack
// flag. A transaction completes at a rising edge with valid high and stall low.
// The configuration port writes rest_length (index 0) or spring_stiffness
// (index 1) whenever cfg_write is high; other indexes are ignored.
// One new transaction can be accepted in every cycle while in_stall is low.
// Most stages belong to the square root, which retires one root bit per
// stage, and to the three dividers, which retire one quotient bit per stage.
// Reset clears all valid bits and sets rest_length to 0 and spring_stiffness
// to 1.0. When the receiver stalls, the output register holds its result and
// one more result lands in a skid register; the input is then stalled and the
// whole pipeline holds until the skid register drains. Nothing is dropped.
module bungee_force_core
  import bf_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [REG_WIDTH-1:0]          cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [WORD_WIDTH-1:0]  body_x,
  input  logic signed [WORD_WIDTH-1:0]  body_y,
  input  logic signed [WORD_WIDTH-1:0]  body_z,
  input  logic signed [WORD_WIDTH-1:0]  other_x,
  input  logic signed [WORD_WIDTH-1:0]  other_y,
  input  logic signed [WORD_WIDTH-1:0]  other_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [WORD_WIDTH-1:0]  force_x,
  output logic signed [WORD_WIDTH-1:0]  force_y,
  output logic signed [WORD_WIDTH-1:0]  force_z,
  output logic                          slack
);

  localparam int W    = WORD_WIDTH;
  localparam int AW   = W + 1;
  localparam int RW   = W + 1;
  localparam int SW   = 2 * RW;
  localparam int TW   = RW + 3;
  localparam int CW   = (RW > REG_WIDTH) ? RW : REG_WIDTH;
  localparam int KW   = REG_WIDTH + RW;
  localparam int MAGW = (W + FRAC_BITS > MAG_LIMIT_BITS) ? MAG_LIMIT_BITS : W + FRAC_BITS;
  localparam int CLAMP_POS = FRAC_BITS + MAG_LIMIT_BITS;
  localparam int LOW  = (MAGW + 1) / 2;
  localparam int HIW  = MAGW - LOW;
  localparam int PW   = MAGW + AW;

  logic [REG_WIDTH-1:0] rest_length;
  logic [REG_WIDTH-1:0] spring_stiffness;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length      <= REST_LENGTH_RESET;
      spring_stiffness <= SPRING_STIFFNESS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_REST_LENGTH:      rest_length      <= cfg_data;
        CFG_SPRING_STIFFNESS: spring_stiffness <= cfg_data;
        default: ;
      endcase
    end
  end

  logic skid_valid;
  logic adv;
  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  // Front: differences, squares, sum of squares.
  logic                 v0, v1, v2;
  logic [AW-1:0]        ad0 [LANES];
  logic [AW-1:0]        ad1 [LANES];
  logic [AW-1:0]        ad2 [LANES];
  logic [LANES-1:0]     pos0, pos1, pos2;
  logic [SW-1:0]        sq1 [LANES];
  logic [SW-1:0]        sum2;
  logic [AW-1:0]        ad0_next [LANES];
  logic [LANES-1:0]     pos0_next;

  always_comb begin
    logic signed [AW-1:0] b [LANES];
    logic signed [AW-1:0] o [LANES];
    logic signed [AW-1:0] d;
    b[0] = AW'(body_x);
    b[1] = AW'(body_y);
    b[2] = AW'(body_z);
    o[0] = AW'(other_x);
    o[1] = AW'(other_y);
    o[2] = AW'(other_z);
    for (int i = 0; i < LANES; i++) begin
      d            = b[i] - o[i];
      pos0_next[i] = !d[AW-1] && (d != '0);
      ad0_next[i]  = d[AW-1] ? AW'(-d) : AW'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos0 <= pos0_next;
      pos1 <= pos0;
      pos2 <= pos1;
      for (int i = 0; i < LANES; i++) begin
        ad0[i] <= ad0_next[i];
        ad1[i] <= ad0[i];
        ad2[i] <= ad1[i];
        sq1[i] <= SW'(ad0[i] * ad0[i]);
      end
      sum2 <= sq1[0] + sq1[1] + sq1[2];
    end
  end

  // Square root, one root bit per stage.
  logic             qv   [RW];
  logic [SW-1:0]    rad  [RW];
  logic [TW-1:0]    rem  [RW];
  logic [RW-1:0]    root [RW];
  logic [AW-1:0]    qad  [RW][LANES];
  logic [LANES-1:0] qpos [RW];
  logic [SW-1:0]    rad_next  [RW];
  logic [TW-1:0]    rem_next  [RW];
  logic [RW-1:0]    root_next [RW];

  always_comb begin
    logic [SW-1:0] rin;
    logic [TW-1:0] min;
    logic [RW-1:0] tin;
    logic [TW-1:0] cur;
    logic [TW-1:0] trial;
    logic          ge;
    for (int s = 0; s < RW; s++) begin
      if (s == 0) begin
        rin = sum2;
        min = '0;
        tin = '0;
      end else begin
        rin = rad[s-1];
        min = rem[s-1];
        tin = root[s-1];
      end
      cur          = {min[TW-3:0], rin[SW-1 -: 2]};
      trial        = {1'b0, tin, 2'b01};
      ge           = cur >= trial;
      rem_next[s]  = ge ? cur - trial : cur;
      root_next[s] = {tin[RW-2:0], ge};
      rad_next[s]  = {rin[SW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < RW; s++) qv[s] <= 1'b0;
    end else if (adv) begin
      for (int s = 0; s < RW; s++) qv[s] <= (s == 0) ? v2 : qv[(s == 0) ? 0 : s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < RW; s++) begin
        rad[s]  <= rad_next[s];
        rem[s]  <= rem_next[s];
        root[s] <= root_next[s];
        qpos[s] <= (s == 0) ? pos2 : qpos[(s == 0) ? 0 : s-1];
        for (int i = 0; i < LANES; i++)
          qad[s][i] <= (s == 0) ? ad2[i] : qad[(s == 0) ? 0 : s-1][i];
      end
    end
  end

  // Stretch, stiffness product, magnitude, split products.
  logic             ve, vk, vm, vp1, vp2;
  logic [RW-1:0]    me, mk, mm, mp1, mp2;
  logic [RW-1:0]    ee;
  logic             slk_e, slk_k, slk_m, slk_p1, slk_p2;
  logic [LANES-1:0] pos_e, pos_k, pos_m, pos_p1, pos_p2;
  logic [AW-1:0]    ad_e [LANES];
  logic [AW-1:0]    ad_k [LANES];
  logic [AW-1:0]    ad_m [LANES];
  logic [KW-1:0]    kp;
  logic [MAGW-1:0]  mag;
  logic [LOW+AW-1:0] pl [LANES];
  logic [HIW+AW-1:0] ph [LANES];
  logic [PW-1:0]    prod [LANES];

  logic [CW-1:0]   m_ext, rest_ext;
  logic [CW-1:0]   e_full;
  logic [KW-1:0]   kp_hi;
  logic [MAGW-1:0] mag_next;

  assign m_ext    = CW'(root[RW-1]);
  assign rest_ext = CW'(rest_length);
  assign e_full   = m_ext - rest_ext;
  assign kp_hi    = kp >> CLAMP_POS;
  assign mag_next = (kp_hi != '0) ? '1 : kp[FRAC_BITS +: MAGW];

  always_ff @(posedge clk) begin
    if (rst) begin
      ve  <= 1'b0;
      vk  <= 1'b0;
      vm  <= 1'b0;
      vp1 <= 1'b0;
      vp2 <= 1'b0;
    end else if (adv) begin
      ve  <= qv[RW-1];
      vk  <= ve;
      vm  <= vk;
      vp1 <= vm;
      vp2 <= vp1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      me     <= root[RW-1];
      ee     <= e_full[RW-1:0];
      slk_e  <= m_ext <= rest_ext;
      pos_e  <= qpos[RW-1];
      mk     <= me;
      kp     <= KW'(spring_stiffness * ee);
      slk_k  <= slk_e;
      pos_k  <= pos_e;
      mm     <= mk;
      mag    <= mag_next;
      slk_m  <= slk_k;
      pos_m  <= pos_k;
      mp1    <= mm;
      slk_p1 <= slk_m;
      pos_p1 <= pos_m;
      mp2    <= mp1;
      slk_p2 <= slk_p1;
      pos_p2 <= pos_p1;
      for (int i = 0; i < LANES; i++) begin
        ad_e[i] <= qad[RW-1][i];
        ad_k[i] <= ad_e[i];
        ad_m[i] <= ad_k[i];
        pl[i]   <= (LOW+AW)'(mag[LOW-1:0] * ad_m[i]);
        ph[i]   <= (HIW+AW)'(mag[MAGW-1:LOW] * ad_m[i]);
        prod[i] <= (PW'(ph[i]) << LOW) + PW'(pl[i]);
      end
    end
  end

  // Three dividers by m, one quotient bit per stage.
  logic             dv   [MAGW];
  logic [RW-1:0]    dm   [MAGW];
  logic             dslk [MAGW];
  logic [LANES-1:0] dpos [MAGW];
  logic [RW-1:0]    drem [MAGW][LANES];
  logic [MAGW-1:0]  dnq  [MAGW][LANES];
  logic [RW-1:0]    drem_next [MAGW][LANES];
  logic [MAGW-1:0]  dnq_next  [MAGW][LANES];

  always_comb begin
    logic [RW-1:0]   rin;
    logic [MAGW-1:0] nin;
    logic [RW-1:0]   mdiv;
    logic [RW:0]     cur;
    logic [RW:0]     diff;
    logic            ge;
    for (int s = 0; s < MAGW; s++) begin
      mdiv = (s == 0) ? mp2 : dm[(s == 0) ? 0 : s-1];
      for (int i = 0; i < LANES; i++) begin
        if (s == 0) begin
          rin = prod[i][PW-1:MAGW];
          nin = prod[i][MAGW-1:0];
        end else begin
          rin = drem[s-1][i];
          nin = dnq[s-1][i];
        end
        cur  = {rin, nin[MAGW-1]};
        ge   = cur >= {1'b0, mdiv};
        diff = cur - {1'b0, mdiv};
        drem_next[s][i] = ge ? diff[RW-1:0] : cur[RW-1:0];
        dnq_next[s][i]  = {nin[MAGW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < MAGW; s++) dv[s] <= 1'b0;
    end else if (adv) begin
      for (int s = 0; s < MAGW; s++) dv[s] <= (s == 0) ? vp2 : dv[(s == 0) ? 0 : s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < MAGW; s++) begin
        dm[s]   <= (s == 0) ? mp2 : dm[(s == 0) ? 0 : s-1];
        dslk[s] <= (s == 0) ? slk_p2 : dslk[(s == 0) ? 0 : s-1];
        dpos[s] <= (s == 0) ? pos_p2 : dpos[(s == 0) ? 0 : s-1];
        for (int i = 0; i < LANES; i++) begin
          drem[s][i] <= drem_next[s][i];
          dnq[s][i]  <= dnq_next[s][i];
        end
      end
    end
  end

  // Sign, saturation and output staging.
  logic [W-1:0] f_next [LANES];
  logic         slk_next;

  always_comb begin
    logic [MAGW-1:0] lim_pos;
    logic [MAGW-1:0] lim_neg;
    logic [MAGW-1:0] q;
    lim_pos = {{(MAGW-W+1){1'b0}}, {(W-1){1'b1}}};
    lim_neg = lim_pos + MAGW'(1);
    slk_next = dslk[MAGW-1];
    for (int i = 0; i < LANES; i++) begin
      q = dnq[MAGW-1][i];
      if (dslk[MAGW-1]) begin
        f_next[i] = '0;
      end else if (dpos[MAGW-1][i]) begin
        if (q > lim_neg) q = lim_neg;
        f_next[i] = W'(-q[W-1:0]);
      end else begin
        if (q > lim_pos) q = lim_pos;
        f_next[i] = q[W-1:0];
      end
    end
  end

  logic         out_take;
  logic         incoming;
  logic [W-1:0] skid_f [LANES];
  logic         skid_slk;

  assign out_take = out_valid && !out_stall;
  assign incoming = adv && dv[MAGW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) skid_valid <= 1'b0;
    end else if (incoming) begin
      if (!out_valid || out_take) out_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        force_x <= skid_f[0];
        force_y <= skid_f[1];
        force_z <= skid_f[2];
        slack   <= skid_slk;
      end
    end else if (incoming) begin
      if (!out_valid || out_take) begin
        force_x <= f_next[0];
        force_y <= f_next[1];
        force_z <= f_next[2];
        slack   <= slk_next;
      end else begin
        for (int i = 0; i < LANES; i++) skid_f[i] <= f_next[i];
        skid_slk <= slk_next;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled without a stalled output");

  a_slack_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && slack) |-> (force_x == '0 && force_y == '0 && force_z == '0))
    else $error("slack result carries a nonzero force");

  a_hold_when_skid: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_take) |=> skid_valid && out_valid)
    else $error("stalled results were lost");

endmodule
